### rtl/core/two_channel_lux_calc_unit_defines.svh
// Assertion macros shared by the lux calculation RTL.
`ifndef TWO_CHANNEL_LUX_CALC_UNIT_DEFINES_SVH
`define TWO_CHANNEL_LUX_CALC_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TLC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tlc_pkg.sv
// Shared constants, types and the power table of the lux calculation block.
`default_nettype none

package tlc_pkg;

  localparam int unsigned COUNT_W         = 16;
  localparam int unsigned LUX_W           = 27;
  localparam int unsigned RATIO_FRAC_BITS = 16;
  localparam int unsigned LUX_FRAC_BITS   = 16;
  localparam int unsigned POW_TABLE_DEPTH = 64;

  // Ratio below 2.0 once the early range check has passed.
  localparam int unsigned RATIO_W   = RATIO_FRAC_BITS + 1;
  localparam int unsigned POW_IDX_W = $clog2(POW_TABLE_DEPTH);
  localparam int unsigned INTERP_W  = RATIO_FRAC_BITS - POW_IDX_W - 1;
  localparam int unsigned POW_W     = 30;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned LUX_SHIFT = COEF_W - LUX_FRAC_BITS;
  localparam int unsigned PROD_W    = COEF_W + COUNT_W;
  localparam int unsigned VAL_W     = PROD_W - LUX_SHIFT;

  localparam logic [COUNT_W-1:0] SAT_COUNT = '1;
  localparam logic [LUX_W-1:0]   LUX_MAX   = '1;
  localparam logic [63:0]        Q30_ONE   = 64'd1 << 30;

  // Segment coefficients, Q0.32, rounded to nearest.
  localparam logic [COEF_W-1:0] C_LOW_A = COEF_W'(((64'd304 << 32) + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] C_LOW_B = COEF_W'(((64'd62 << 32) + 64'd500) / 64'd1000);
  localparam logic [COEF_W-1:0] C_S1_A  = COEF_W'(((64'd224 << 32) + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] C_S1_B  = COEF_W'(((64'd31 << 32) + 64'd500) / 64'd1000);
  localparam logic [COEF_W-1:0] C_S2_A  = COEF_W'(((64'd128 << 32) + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] C_S2_B  = COEF_W'(((64'd153 << 32) + 64'd5000) / 64'd10000);
  localparam logic [COEF_W-1:0] C_S3_A  = COEF_W'(((64'd146 << 32) + 64'd50000) / 64'd100000);
  localparam logic [COEF_W-1:0] C_S3_B  = COEF_W'(((64'd112 << 32) + 64'd50000) / 64'd100000);

  // Ratio thresholds with RATIO_FRAC_BITS fraction bits.
  localparam logic [RATIO_W-1:0] RATIO_HALF = RATIO_W'(64'd1 << (RATIO_FRAC_BITS - 1));
  localparam logic [RATIO_W-1:0] THR_061 =
    RATIO_W'(((64'd61 << RATIO_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [RATIO_W-1:0] THR_080 =
    RATIO_W'(((64'd80 << RATIO_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [RATIO_W-1:0] THR_130 =
    RATIO_W'(((64'd130 << RATIO_FRAC_BITS) + 64'd50) / 64'd100);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_RANGE = 2'd2,
    ST_DARK  = 2'd3
  } lux_status_t;

  typedef logic [POW_TABLE_DEPTH:0][POW_W-1:0] pow_tab_t;

  typedef struct packed {
    logic [COUNT_W-1:0] d0;
    logic [COUNT_W-1:0] d1;
    lux_status_t        st;
    logic [RATIO_W-1:0] ratio;
  } div_rsp_t;

  // Fifth power in Q0.30, truncating after every product.
  function automatic logic [63:0] fifth_power(input logic [63:0] y);
    logic [63:0] q;
    q = y;
    for (int k = 0; k < 4; k++) begin
      q = (q * y) >> 30;
    end
    return q;
  endfunction

  // ratio^1.4 at POW_TABLE_DEPTH+1 points over [0, 0.5], Q0.30.
  function automatic pow_tab_t build_pow_table();
    pow_tab_t    tab;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] y;
    logic [63:0] cand;
    tab = '0;
    for (int i = 0; i <= POW_TABLE_DEPTH; i++) begin
      x = (64'(i) << 29) / POW_TABLE_DEPTH;
      s = (x * x) >> 30;
      y = '0;
      for (int b = 30; b >= 0; b--) begin
        cand = y | (64'd1 << b);
        if (cand <= Q30_ONE && fifth_power(cand) <= s) begin
          y = cand;
        end
      end
      tab[i] = POW_W'((x * y) >> 30);
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TABLE = build_pow_table();

endpackage

`default_nettype wire

### rtl/core/tlc_if.sv
// Request and result channel interfaces of the lux calculation block.
`default_nettype none

interface tlc_in_if;
  logic                         valid;
  logic                         ready;
  logic [tlc_pkg::COUNT_W-1:0]  broadband_count;
  logic [tlc_pkg::COUNT_W-1:0]  infrared_count;

  modport source (output valid, output broadband_count, output infrared_count, input ready);
  modport sink   (input valid, input broadband_count, input infrared_count, output ready);
endinterface

interface tlc_out_if;
  logic                       valid;
  logic                       ready;
  logic [tlc_pkg::LUX_W-1:0]  lux_value;
  logic [1:0]                 lux_status;

  modport source (output valid, output lux_value, output lux_status, input ready);
  modport sink   (input valid, input lux_value, input lux_status, output ready);
endinterface

`default_nettype wire

### rtl/core/two_channel_lux_calc_unit.sv
// Top level of the two-channel lux calculation: ratio divider, segment pipeline, result register.
//
// Usage:
//   in_ch  carries one request: broadband_count and infrared_count (16 bits each).
//   out_ch carries one result per request: lux_value (unsigned Q11.16) and lux_status
//   (0 ok, 1 saturated channel, 2 ratio out of range, 3 dark). lux_value is 0 unless ok.
//   Both channels move a request on a clock edge where valid and ready are high.
// Timing:
//   From acceptance to out_ch.valid a request passes one entry stage, 17 divider
//   stages (one quotient bit each), four segment stages and the result register.
//   Throughput is one request per cycle unless out_ch stalls; the divider sets the latency.
// Reset:
//   rst_n (synchronous, active low) empties every stage; payload registers keep data.
// Back-pressure:
//   Each stage loads when empty or when its contents move on, so bubbles close up and
//   in_ch.ready stays high while any stage is free. A stalled result holds in the output
//   register; nothing is dropped or repeated.
`default_nettype none

module two_channel_lux_calc_unit (
  input  wire        clk,
  input  wire        rst_n,
  tlc_in_if.sink     in_ch,
  tlc_out_if.source  out_ch
);

`include "two_channel_lux_calc_unit_defines.svh"

  // Stage A: segment picked, table points read, coefficients chosen.
  typedef struct packed {
    logic [tlc_pkg::COUNT_W-1:0]  d0;
    logic [tlc_pkg::COUNT_W-1:0]  d1;
    tlc_pkg::lux_status_t         st;
    logic                         is_low;
    logic [tlc_pkg::COEF_W-1:0]   coef_a;
    logic [tlc_pkg::COEF_W-1:0]   coef_b;
    logic [tlc_pkg::POW_W-1:0]    e0;
    logic [tlc_pkg::POW_W-1:0]    e1;
    logic [tlc_pkg::INTERP_W-1:0] frac;
  } stage_a_t;

  // Stage B: interpolated power, linear segment products.
  typedef struct packed {
    logic [tlc_pkg::COUNT_W-1:0] d0;
    tlc_pkg::lux_status_t        st;
    logic                        is_low;
    logic [tlc_pkg::POW_W-1:0]   pw;
    logic [tlc_pkg::PROD_W-1:0]  pa;
    logic [tlc_pkg::PROD_W-1:0]  pb;
  } stage_b_t;

  // Stage C: low segment coefficient, linear segment value.
  typedef struct packed {
    logic [tlc_pkg::COUNT_W-1:0] d0;
    tlc_pkg::lux_status_t        st;
    logic                        is_low;
    logic [tlc_pkg::COEF_W-1:0]  k;
    logic [tlc_pkg::VAL_W-1:0]   lin_val;
  } stage_c_t;

  // Stage D: unclamped lux.
  typedef struct packed {
    logic [tlc_pkg::COUNT_W-1:0] d0;
    tlc_pkg::lux_status_t        st;
    logic [tlc_pkg::VAL_W-1:0]   val;
  } stage_d_t;

  logic              div_rsp_valid;
  tlc_pkg::div_rsp_t div_rsp;

  stage_a_t a_r, a_nxt;
  stage_b_t b_r, b_nxt;
  stage_c_t c_r, c_nxt;
  stage_d_t d_r, d_nxt;
  logic     a_vld_r, b_vld_r, c_vld_r, d_vld_r;

  logic                     out_valid_r;
  logic [tlc_pkg::LUX_W-1:0] out_lux_r, out_lux_nxt;
  tlc_pkg::lux_status_t     out_status_r;

  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_out;

  // Ready chain: a stage takes a new request when empty or draining.
  assign rdy_out = !out_valid_r || out_ch.ready;
  assign rdy_d   = !d_vld_r || rdy_out;
  assign rdy_c   = !c_vld_r || rdy_d;
  assign rdy_b   = !b_vld_r || rdy_c;
  assign rdy_a   = !a_vld_r || rdy_b;

  tlc_ratio_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req_d0    (in_ch.broadband_count),
    .req_d1    (in_ch.infrared_count),
    .rsp_valid (div_rsp_valid),
    .rsp_ready (rdy_a),
    .rsp       (div_rsp)
  );

  // Stage A: classify the ratio and read the two neighbouring power table points.
  logic [tlc_pkg::POW_IDX_W-1:0] pow_idx;
  logic [tlc_pkg::POW_IDX_W:0]   pow_idx0;
  logic [tlc_pkg::POW_IDX_W:0]   pow_idx1;

  always_comb begin
    pow_idx  = div_rsp.ratio[tlc_pkg::RATIO_FRAC_BITS-2:tlc_pkg::INTERP_W];
    pow_idx0 = {1'b0, pow_idx};
    pow_idx1 = pow_idx0 + (tlc_pkg::POW_IDX_W+1)'(1);

    a_nxt.d0     = div_rsp.d0;
    a_nxt.d1     = div_rsp.d1;
    a_nxt.st     = div_rsp.st;
    a_nxt.is_low = div_rsp.ratio < tlc_pkg::RATIO_HALF;
    a_nxt.e0     = tlc_pkg::POW_TABLE[pow_idx0];
    a_nxt.e1     = tlc_pkg::POW_TABLE[pow_idx1];
    a_nxt.frac   = div_rsp.ratio[tlc_pkg::INTERP_W-1:0];

    if (div_rsp.st == tlc_pkg::ST_OK && div_rsp.ratio >= tlc_pkg::THR_130) begin
      a_nxt.st = tlc_pkg::ST_RANGE;
    end

    if (div_rsp.ratio < tlc_pkg::THR_061) begin
      a_nxt.coef_a = tlc_pkg::C_S1_A;
      a_nxt.coef_b = tlc_pkg::C_S1_B;
    end else if (div_rsp.ratio < tlc_pkg::THR_080) begin
      a_nxt.coef_a = tlc_pkg::C_S2_A;
      a_nxt.coef_b = tlc_pkg::C_S2_B;
    end else begin
      a_nxt.coef_a = tlc_pkg::C_S3_A;
      a_nxt.coef_b = tlc_pkg::C_S3_B;
    end
  end

  // Stage B: interpolate between table points; form both linear segment products.
  localparam int unsigned IP_W = tlc_pkg::POW_W + tlc_pkg::INTERP_W;
  logic [IP_W-1:0] interp_prod;

  always_comb begin
    interp_prod  = IP_W'(a_r.e1 - a_r.e0) * IP_W'(a_r.frac);
    b_nxt.d0     = a_r.d0;
    b_nxt.st     = a_r.st;
    b_nxt.is_low = a_r.is_low;
    b_nxt.pw     = a_r.e0 + tlc_pkg::POW_W'(interp_prod >> tlc_pkg::INTERP_W);
    b_nxt.pa     = tlc_pkg::PROD_W'(a_r.coef_a) * tlc_pkg::PROD_W'(a_r.d0);
    b_nxt.pb     = tlc_pkg::PROD_W'(a_r.coef_b) * tlc_pkg::PROD_W'(a_r.d1);
  end

  // Stage C: low segment coefficient k = 0.0304 - 0.062 * ratio^1.4; linear difference.
  localparam int unsigned TP_W = tlc_pkg::COEF_W + tlc_pkg::POW_W;
  logic [TP_W-1:0]             t_prod;
  logic [tlc_pkg::COEF_W-1:0]  t_val;
  logic [tlc_pkg::PROD_W-1:0]  lin_diff;

  always_comb begin
    t_prod   = TP_W'(tlc_pkg::C_LOW_B) * TP_W'(b_r.pw);
    t_val    = tlc_pkg::COEF_W'(t_prod >> tlc_pkg::POW_W);
    lin_diff = b_r.pa - b_r.pb;

    c_nxt.d0     = b_r.d0;
    c_nxt.st     = b_r.st;
    c_nxt.is_low = b_r.is_low;
    c_nxt.k      = (tlc_pkg::C_LOW_A > t_val) ? (tlc_pkg::C_LOW_A - t_val) : '0;
    // Clamp a negative segment result to zero.
    c_nxt.lin_val = (b_r.pa > b_r.pb) ?
                    tlc_pkg::VAL_W'(lin_diff >> tlc_pkg::LUX_SHIFT) : '0;
  end

  // Stage D: scale broadband by k for the low segment.
  logic [tlc_pkg::PROD_W-1:0] low_prod;

  always_comb begin
    low_prod = tlc_pkg::PROD_W'(c_r.k) * tlc_pkg::PROD_W'(c_r.d0);
    d_nxt.d0 = c_r.d0;
    d_nxt.st = c_r.st;
    d_nxt.val = c_r.is_low ? tlc_pkg::VAL_W'(low_prod >> tlc_pkg::LUX_SHIFT) : c_r.lin_val;
  end

  // Result: saturate to 27 bits, force zero on any fault status.
  always_comb begin
    if (d_r.st != tlc_pkg::ST_OK) begin
      out_lux_nxt = '0;
    end else if (d_r.val > tlc_pkg::VAL_W'(tlc_pkg::LUX_MAX)) begin
      out_lux_nxt = tlc_pkg::LUX_MAX;
    end else begin
      out_lux_nxt = d_r.val[tlc_pkg::LUX_W-1:0];
    end
  end

  // Valid bits: clear on reset, advance with their stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy_a)   a_vld_r     <= div_rsp_valid;
      if (rdy_b)   b_vld_r     <= a_vld_r;
      if (rdy_c)   c_vld_r     <= b_vld_r;
      if (rdy_d)   d_vld_r     <= c_vld_r;
      if (rdy_out) out_valid_r <= d_vld_r;
    end
  end

  // Payload: load with the stage, hold while stalled.
  always_ff @(posedge clk) begin
    if (rdy_a) a_r <= a_nxt;
    if (rdy_b) b_r <= b_nxt;
    if (rdy_c) c_r <= c_nxt;
    if (rdy_d) d_r <= d_nxt;
    if (rdy_out) begin
      out_lux_r    <= out_lux_nxt;
      out_status_r <= d_r.st;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.lux_value  = out_lux_r;
  assign out_ch.lux_status = out_status_r;

  `TLC_ASSERT_IMPLY(a_fault_zero, out_valid_r && out_status_r != tlc_pkg::ST_OK, out_lux_r == '0, "lux not zero on fault")
  `TLC_ASSERT_IMPLY(a_dark_bb_zero, d_vld_r && d_r.st == tlc_pkg::ST_DARK, d_r.d0 == '0, "dark with broadband count")
  `TLC_ASSERT_IMPLY(a_sat_count, a_vld_r && a_r.st == tlc_pkg::ST_SAT, a_r.d0 == tlc_pkg::SAT_COUNT || a_r.d1 == tlc_pkg::SAT_COUNT, "saturation without full count")

endmodule

`default_nettype wire

### rtl/core/tlc_ratio_div.sv
// Pipelined restoring divider forming infrared / broadband, one quotient bit per stage.
`default_nettype none

module tlc_ratio_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          req_valid,
  output logic                         req_ready,
  input  wire [tlc_pkg::COUNT_W-1:0]   req_d0,
  input  wire [tlc_pkg::COUNT_W-1:0]   req_d1,
  output logic                         rsp_valid,
  input  wire                          rsp_ready,
  output tlc_pkg::div_rsp_t            rsp
);

`include "two_channel_lux_calc_unit_defines.svh"

  localparam int unsigned STAGES = tlc_pkg::RATIO_W;
  localparam int unsigned CHK_W  = tlc_pkg::RATIO_W + tlc_pkg::COUNT_W + 1;

  typedef struct packed {
    logic [tlc_pkg::COUNT_W-1:0] d0;
    logic [tlc_pkg::COUNT_W-1:0] d1;
    tlc_pkg::lux_status_t        st;
    logic [tlc_pkg::COUNT_W-1:0] rem;
    logic [tlc_pkg::RATIO_W-1:0] quo;
  } stage_t;

  stage_t stg_r   [0:STAGES];
  stage_t stg_nxt [0:STAGES];
  logic   vld_r   [0:STAGES];
  logic   vld_in  [0:STAGES];
  logic   rdy     [0:STAGES+1];

  // Special cases are flagged on entry; the quotient is then don't-care.
  always_comb begin
    stg_nxt[0].d0  = req_d0;
    stg_nxt[0].d1  = req_d1;
    stg_nxt[0].rem = {1'b0, req_d1[tlc_pkg::COUNT_W-1:1]};
    stg_nxt[0].quo = '0;
    if (req_d0 == tlc_pkg::SAT_COUNT || req_d1 == tlc_pkg::SAT_COUNT) begin
      stg_nxt[0].st = tlc_pkg::ST_SAT;
    end else if (req_d0 == '0) begin
      stg_nxt[0].st = tlc_pkg::ST_DARK;
    end else if ({1'b0, req_d1} >= {req_d0, 1'b0}) begin
      stg_nxt[0].st = tlc_pkg::ST_RANGE;
    end else begin
      stg_nxt[0].st = tlc_pkg::ST_OK;
    end
  end

  assign vld_in[0]    = req_valid;
  assign rdy[STAGES+1] = rsp_ready;
  assign req_ready    = rdy[0];

  for (genvar j = 1; j <= STAGES; j++) begin : g_div
    localparam int unsigned BIT_POS = STAGES - j;
    logic                        nbit;
    logic [tlc_pkg::COUNT_W:0]   shifted;
    logic [tlc_pkg::COUNT_W:0]   diff;

    always_comb begin
      nbit    = (BIT_POS == tlc_pkg::RATIO_FRAC_BITS) ? stg_r[j-1].d1[0] : 1'b0;
      shifted = {stg_r[j-1].rem, nbit};
      diff    = shifted - {1'b0, stg_r[j-1].d0};
      stg_nxt[j] = stg_r[j-1];
      if (shifted >= {1'b0, stg_r[j-1].d0}) begin
        stg_nxt[j].rem = diff[tlc_pkg::COUNT_W-1:0];
        stg_nxt[j].quo = {stg_r[j-1].quo[tlc_pkg::RATIO_W-2:0], 1'b1};
      end else begin
        stg_nxt[j].rem = shifted[tlc_pkg::COUNT_W-1:0];
        stg_nxt[j].quo = {stg_r[j-1].quo[tlc_pkg::RATIO_W-2:0], 1'b0};
      end
    end

    assign vld_in[j] = vld_r[j-1];
  end

  for (genvar j = 0; j <= STAGES; j++) begin : g_stage
    // A stage loads when it is empty or its contents move on.
    assign rdy[j] = !vld_r[j] || rdy[j+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld_r[j] <= vld_in[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        stg_r[j] <= stg_nxt[j];
      end
    end
  end

  assign rsp_valid = vld_r[STAGES];
  assign rsp.d0    = stg_r[STAGES].d0;
  assign rsp.d1    = stg_r[STAGES].d1;
  assign rsp.st    = stg_r[STAGES].st;
  assign rsp.ratio = stg_r[STAGES].quo;

  logic             chk_ok;
  logic [CHK_W-1:0] chk_lhs;
  logic [CHK_W-1:0] chk_rhs;

  always_comb begin
    chk_ok  = vld_r[STAGES] && (stg_r[STAGES].st == tlc_pkg::ST_OK);
    chk_lhs = CHK_W'(stg_r[STAGES].quo) * CHK_W'(stg_r[STAGES].d0) + CHK_W'(stg_r[STAGES].rem);
    chk_rhs = CHK_W'(stg_r[STAGES].d1) << tlc_pkg::RATIO_FRAC_BITS;
  end

  `TLC_ASSERT_NEXT(a_div_load, req_valid && req_ready, vld_r[0], "request lost on entry")
  `TLC_ASSERT_IMPLY(a_div_rem, chk_ok, stg_r[STAGES].rem < stg_r[STAGES].d0, "remainder too big")
  `TLC_ASSERT_IMPLY(a_div_exact, chk_ok, chk_lhs == chk_rhs, "quotient and remainder disagree")

endmodule

`default_nettype wire

### sim/tlc_checker.sv
// Checker for the lux calculation block: predicts every accepted request and compares results.
module tlc_checker (
  input  wire          clk,
  input  wire          rst_n,
  tlc_in_if            in_ch,
  tlc_out_if           out_ch,
  output int unsigned  fail_count,
  output int unsigned  pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import tlc_pkg::COUNT_W;
  import tlc_pkg::LUX_W;
  import tlc_pkg::lux_status_t;
  import tlc_pkg::ST_OK;
  import tlc_pkg::ST_SAT;
  import tlc_pkg::ST_RANGE;
  import tlc_pkg::ST_DARK;

  localparam int unsigned    R_FRAC     = 16;
  localparam int unsigned    L_SHIFT    = 16;
  localparam int unsigned    PTS        = 64;
  localparam logic [15:0]    FULL_SCALE = 16'hFFFF;
  localparam logic [63:0]    LUX_CEIL   = (64'd1 << 27) - 64'd1;
  localparam logic [63:0]    UNIT_Q30   = 64'd1 << 30;

  typedef struct packed {
    logic [LUX_W-1:0] lux;
    lux_status_t      status;
  } lux_result_t;

  // Q0.32 coefficient n/d, rounded to nearest
  function automatic logic [63:0] q32_coef(input logic [63:0] n, input logic [63:0] d);
    return ((n << 32) + d / 2) / d;
  endfunction

  // Ratio threshold n/d with R_FRAC fraction bits, rounded to nearest
  function automatic logic [63:0] ratio_thr(input logic [63:0] n, input logic [63:0] d);
    return ((n << R_FRAC) + d / 2) / d;
  endfunction

  localparam logic [63:0] K_LOW_A = q32_coef(304, 10000);
  localparam logic [63:0] K_LOW_B = q32_coef(62, 1000);
  localparam logic [63:0] K_S1_A  = q32_coef(224, 10000);
  localparam logic [63:0] K_S1_B  = q32_coef(31, 1000);
  localparam logic [63:0] K_S2_A  = q32_coef(128, 10000);
  localparam logic [63:0] K_S2_B  = q32_coef(153, 10000);
  localparam logic [63:0] K_S3_A  = q32_coef(146, 100000);
  localparam logic [63:0] K_S3_B  = q32_coef(112, 100000);
  localparam logic [63:0] R_061   = ratio_thr(61, 100);
  localparam logic [63:0] R_080   = ratio_thr(80, 100);
  localparam logic [63:0] R_130   = ratio_thr(130, 100);

  logic [63:0] pow_pts [0:PTS];
  lux_result_t lux_q [$];

  // Q0.30 fifth power, truncated after each product
  function automatic logic [63:0] q30_pow5(input logic [63:0] y);
    logic [63:0] acc;
    acc = y;
    repeat (4) acc = (acc * y) >> 30;
    return acc;
  endfunction

  // x^1.4 as x * (x^2)^(1/5), root found bit by bit from the top
  function automatic logic [63:0] pow14_point(input int unsigned i);
    logic [63:0] x;
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] trial;
    x    = (64'(i) << 29) / PTS;
    sq   = (x * x) >> 30;
    root = '0;
    for (int b = 30; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial <= UNIT_Q30 && q30_pow5(trial) <= sq) root = trial;
    end
    return (x * root) >> 30;
  endfunction

  function automatic logic [63:0] seg_line(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] bb, input logic [63:0] ir);
    logic [63:0] pa;
    logic [63:0] pb;
    pa = a * bb;
    pb = b * ir;
    if (pa <= pb) return '0;
    return (pa - pb) >> L_SHIFT;
  endfunction

  function automatic lux_result_t compute_lux(input logic [COUNT_W-1:0] bb,
                                              input logic [COUNT_W-1:0] ir);
    lux_result_t res;
    logic [63:0] b64;
    logic [63:0] i64;
    logic [63:0] ratio;
    logic [63:0] pos;
    logic [63:0] frac;
    logic [63:0] e0;
    logic [63:0] e1;
    logic [63:0] p;
    logic [63:0] t;
    logic [63:0] k;
    logic [63:0] lux;
    int unsigned idx;
    b64        = 64'(bb);
    i64        = 64'(ir);
    lux        = '0;
    res.status = ST_OK;
    if (bb == FULL_SCALE || ir == FULL_SCALE) begin
      res.status = ST_SAT;
    end else if (bb == '0) begin
      res.status = ST_DARK;
    end else begin
      ratio = (i64 << R_FRAC) / b64;
      if (ratio < (64'd1 << (R_FRAC - 1))) begin
        // interpolate between table points
        pos  = ratio * (2 * PTS);
        idx  = int'(pos >> R_FRAC);
        frac = pos & ((64'd1 << R_FRAC) - 1);
        e0   = pow_pts[idx];
        e1   = pow_pts[idx + 1];
        p    = e0 + (((e1 - e0) * frac) >> R_FRAC);
        t    = (K_LOW_B * p) >> 30;
        k    = (K_LOW_A > t) ? (K_LOW_A - t) : '0;
        lux  = (b64 * k) >> L_SHIFT;
      end else if (ratio < R_061) begin
        lux = seg_line(K_S1_A, K_S1_B, b64, i64);
      end else if (ratio < R_080) begin
        lux = seg_line(K_S2_A, K_S2_B, b64, i64);
      end else if (ratio < R_130) begin
        lux = seg_line(K_S3_A, K_S3_B, b64, i64);
      end else begin
        res.status = ST_RANGE;
      end
    end
    if (lux > LUX_CEIL) lux = LUX_CEIL;
    res.lux = LUX_W'(lux);
    return res;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    for (int i = 0; i <= PTS; i++) pow_pts[i] = pow14_point(i);
  end

  always @(posedge clk) begin
    lux_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        lux_q.push_back(compute_lux(in_ch.broadband_count, in_ch.infrared_count));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (lux_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result: expected none, actual lux %0d status %0d",
                   $time, out_ch.lux_value, out_ch.lux_status);
        end else begin
          want = lux_q.pop_front();
          if (out_ch.lux_value !== want.lux) begin
            fail_count++;
            $display("%0t lux_value mismatch: expected %0d, actual %0d",
                     $time, want.lux, out_ch.lux_value);
          end
          if (out_ch.lux_status !== want.status) begin
            fail_count++;
            $display("%0t lux_status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_ch.lux_status);
          end
        end
      end
    end
    pending_count = lux_q.size();
  end

endmodule

### sim/tb.sv
// Top of the lux calculation testbench: clock, reset, request stimulus, result stalls, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_COUNT = 1780;
  // Cycles to let pass after the last result before the verdict
  localparam int unsigned DRAIN_WAIT   = 30;

  logic        clk;
  logic        rst_n;
  // Set while both sides must run without gaps or stalls
  bit          steady;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned pending_count;

  tlc_in_if  req_ch ();
  tlc_out_if res_ch ();

  two_channel_lux_calc_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  tlc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (req_ch),
    .out_ch        (res_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake: stop the run once the cycle budget is spent.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[two_channel_lux_calc_unit] ERROR");
      $finish;
    end
  end

  // Result side: stall at random with a chance of 16 in a hundred, never while steady is set.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= steady || ($urandom_range(99) >= 16);
    end
  end

  // Offer one request and hold it until the block takes it. Insert a random gap first
  // unless steady is set; valid changes at most once per falling edge.
  task automatic send_counts(input logic [15:0] bb, input logic [15:0] ir);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 16) begin
        req_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_ch.valid           <= 1'b1;
    req_ch.broadband_count <= bb;
    req_ch.infrared_count  <= ir;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Build one random request. Most pick a ratio band and scale the infrared count
  // from the broadband one, so every segment and threshold sees plenty of traffic;
  // the rest are saturated, dark or fully random pairs.
  task automatic send_random();
    logic [15:0] bb;
    logic [15:0] ir;
    logic [63:0] scaled;
    logic [31:0] ratio;
    int unsigned pick;
    pick = $urandom_range(99);
    bb   = 16'($urandom_range(65534, 1) >> $urandom_range(15, 0));
    if (bb == '0) bb = 16'd1;
    if (pick < 5) begin
      // saturated: one channel or both at full scale
      case ($urandom_range(2))
        0:       begin bb = 16'hFFFF; ir = 16'($urandom); end
        1:       begin ir = 16'hFFFF; bb = 16'($urandom); end
        default: begin bb = 16'hFFFF; ir = 16'hFFFF; end
      endcase
    end else if (pick < 9) begin
      bb = '0;
      ir = 16'($urandom);
    end else if (pick < 19) begin
      bb = 16'($urandom);
      ir = 16'($urandom);
    end else begin
      case ($urandom_range(4))
        0:       ratio = $urandom_range(32767, 0);
        1:       ratio = $urandom_range(39977, 32768);
        2:       ratio = $urandom_range(52429, 39976);
        3:       ratio = $urandom_range(85197, 52428);
        default: ratio = $urandom_range(200000, 85196);
      endcase
      scaled = (64'(bb) * 64'(ratio)) >> 16;
      scaled = scaled + 64'($urandom_range(1));
      if (scaled > 64'd65534) scaled = 64'd65534;
      ir = 16'(scaled);
    end
    send_counts(bb, ir);
  endtask

  initial begin
    rst_n                  = 1'b0;
    req_ch.valid           = 1'b0;
    req_ch.broadband_count = '0;
    req_ch.infrared_count  = '0;
    steady                 = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: dark and saturated pairs, extremes, band edges.
    send_counts(16'd0,     16'd0);
    send_counts(16'd0,     16'd1234);
    send_counts(16'd0,     16'd65534);
    send_counts(16'hFFFF,  16'd0);
    send_counts(16'd0,     16'hFFFF);
    send_counts(16'hFFFF,  16'hFFFF);
    send_counts(16'd65534, 16'd0);
    send_counts(16'd1,     16'd0);
    send_counts(16'd65534, 16'd32766);
    send_counts(16'd65534, 16'd32767);
    send_counts(16'd10,    16'd5);
    send_counts(16'd65534, 16'd12345);
    send_counts(16'd1000,  16'd7);
    // Just under and over 0.61, 0.80 and 1.30
    send_counts(16'd100,   16'd61);
    send_counts(16'd100,   16'd62);
    send_counts(16'd100,   16'd80);
    send_counts(16'd100,   16'd81);
    send_counts(16'd100,   16'd130);
    send_counts(16'd100,   16'd131);
    send_counts(16'd1,     16'd1);
    send_counts(16'd1,     16'd65534);
    send_counts(16'd65534, 16'd65534);

    // Random part, with a stretch of back-to-back traffic in the middle.
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      steady = (n >= 700 && n < 1000);
      send_random();
    end
    steady = 1'b0;

    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Drain every outstanding result, then watch for stray ones.
    wait (pending_count == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("[two_channel_lux_calc_unit] OK");
    end else begin
      $display("[two_channel_lux_calc_unit] ERROR");
    end
    $finish;
  end

endmodule
